// ===== rtl/spt_pkg.sv =====
package spt_pkg;

  // table geometry; TABLE_ENTRIES must be a power of two
  localparam int TABLE_ENTRIES = 128;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int ADDR_BITS     = 32;
  localparam int STRIDE_W      = ADDR_BITS + 1;
  localparam int CAND_W        = ADDR_BITS + 2;

  localparam logic [ADDR_BITS-1:0] TOP_ADDR_RESET = ADDR_BITS'(32'h0FFF_FFFF);

  typedef logic [ADDR_BITS-1:0]       addr_t;
  typedef logic signed [STRIDE_W-1:0] stride_t;
  typedef logic [SLOT_W-1:0]          slot_t;

  // one table entry: last data address and last stride
  typedef struct packed {
    stride_t stride;
    addr_t   last;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // training result handed to the issue stage
  typedef struct packed {
    addr_t   da;
    stride_t cur;
    logic    match;
  } train_t;

endpackage

// ===== rtl/stride_prefetch_table.sv =====
// stride prefetcher: a direct-mapped table of 128 entries, picked by the low
// bits of the instruction address, keeps the last data address and stride of
// each slot. every input beat gives exactly one result beat; when the stride
// repeats and data address plus stride lies in 0..top_address, the result
// carries prefetch_valid = 1 and that address, otherwise prefetch_valid = 0
// and address 0. one beat per cycle sustained while out_ready stays high. the
// table lives in one synchronous ram, so a beat reads its entry when it is
// accepted, updates and writes it back from stage 1 as it moves on, and the
// candidate check and output register follow. back-to-back
// beats on the same slot are forwarded around the ram. after reset the table
// reads as untrained at once (per-entry valid bits), no clearing pass.
// top_address (reset 0x0fffffff) should only be written while no beat is in
// flight.
module stride_prefetch_table (
  input  logic                    clk,
  input  logic                    rst_n,
  // access channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [31:0]             in_instr_addr,
  input  logic [31:0]             in_data_addr,
  // prefetch candidate channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_prefetch_valid,
  output logic [31:0]             out_prefetch_addr,
  // top_address register
  input  logic                    cfg_we,
  input  logic [31:0]             cfg_wdata
);

  import spt_pkg::*;

  // configuration: highest address a prefetch may target
  addr_t  top_address_r;

  // stage 1 -> stage 2 beat
  logic   trn_valid;
  logic   trn_ready;
  train_t trn;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_address_r <= TOP_ADDR_RESET;
    end else if (cfg_we) begin
      top_address_r <= cfg_wdata;
    end
  end

  // table read, stride training and write-back
  spt_train u_train (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc_valid     (in_valid),
    .acc_ready     (in_ready),
    .acc_instr_addr(in_instr_addr),
    .acc_data_addr (in_data_addr),
    .trn_valid     (trn_valid),
    .trn_ready     (trn_ready),
    .trn           (trn)
  );

  // candidate range check and output register
  spt_issue u_issue (
    .clk               (clk),
    .rst_n             (rst_n),
    .trn_valid         (trn_valid),
    .trn_ready         (trn_ready),
    .trn               (trn),
    .top_address       (top_address_r),
    .res_valid         (out_valid),
    .res_ready         (out_ready),
    .res_prefetch_valid(out_prefetch_valid),
    .res_prefetch_addr (out_prefetch_addr)
  );

endmodule

// ===== rtl/spt_ram.sv =====
module spt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/spt_train.sv =====
module spt_train (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc_valid,
  output logic            acc_ready,
  input  spt_pkg::addr_t  acc_instr_addr,
  input  spt_pkg::addr_t  acc_data_addr,
  output logic            trn_valid,
  input  logic            trn_ready,
  output spt_pkg::train_t trn
);

  import spt_pkg::*;

  logic [TABLE_ENTRIES-1:0] vld_r;
  logic                     s1_v_r;
  logic                     s1_v_nxt;
  slot_t                    s1_slot_r;
  addr_t                    s1_da_r;
  logic                     rd_vld_r;
  logic                     fwd_hit_r;
  entry_t                   fwd_data_r;

  slot_t                    in_slot;
  logic                     accept;
  logic                     s1_adv;
  logic [ENTRY_W-1:0]       ram_rdata;
  entry_t                   ent;
  entry_t                   wr_ent;
  logic                     trained;
  stride_t                  cur;

  assign in_slot   = acc_instr_addr[SLOT_W-1:0];
  assign s1_adv    = s1_v_r && trn_ready;
  assign acc_ready = !s1_v_r || trn_ready;
  assign accept    = acc_valid && acc_ready;

  spt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (s1_adv),
    .waddr(s1_slot_r),
    .wdata(wr_ent),
    .re   (accept),
    .raddr(in_slot),
    .rdata(ram_rdata)
  );

  // entry as seen by the item in stage 1: forwarded, stored, or reset value
  always_comb begin
    if (fwd_hit_r) begin
      ent = fwd_data_r;
    end else if (rd_vld_r) begin
      ent = entry_t'(ram_rdata);
    end else begin
      ent = '0;
    end
    trained       = (ent.last != '0);
    cur           = stride_t'({1'b0, s1_da_r}) - stride_t'({1'b0, ent.last});
    wr_ent.last   = s1_da_r;
    wr_ent.stride = trained ? cur : ent.stride;
  end

  assign trn_valid = s1_v_r;
  assign trn.da    = s1_da_r;
  assign trn.cur   = cur;
  assign trn.match = trained && (cur == ent.stride);

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      s1_v_r    <= 1'b0;
      fwd_hit_r <= 1'b0;
      rd_vld_r  <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      if (s1_adv) begin
        vld_r[s1_slot_r] <= 1'b1;
      end
      if (accept) begin
        rd_vld_r  <= vld_r[in_slot];
        // the ram returns the old word when read and written together
        fwd_hit_r <= s1_adv && (s1_slot_r == in_slot);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_slot_r  <= in_slot;
      s1_da_r    <= acc_data_addr;
      fwd_data_r <= wr_ent;
    end
  end

`ifndef SYNTHESIS
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_v_r)
    else $error("accepted beat did not reach stage 1");
  a_write_marks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> vld_r[$past(s1_slot_r)])
    else $error("written entry not marked valid");
`endif

endmodule

// ===== rtl/spt_issue.sv =====
module spt_issue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            trn_valid,
  output logic            trn_ready,
  input  spt_pkg::train_t trn,
  input  spt_pkg::addr_t  top_address,
  output logic            res_valid,
  input  logic            res_ready,
  output logic            res_prefetch_valid,
  output spt_pkg::addr_t  res_prefetch_addr
);

  import spt_pkg::*;

  logic                     s2_v_r;
  logic                     s2_v_nxt;
  train_t                   s2_r;
  logic                     out_v_r;
  logic                     out_v_nxt;
  logic                     pf_valid_r;
  addr_t                    pf_addr_r;

  logic                     out_adv;
  logic                     s2_adv;
  logic signed [CAND_W-1:0] cand;
  logic                     pf_ok;

  assign out_adv   = !out_v_r || res_ready;
  assign s2_adv    = s2_v_r && out_adv;
  assign trn_ready = !s2_v_r || out_adv;

  // candidate = data address + stride, kept wide enough to see the sign
  always_comb begin
    cand  = CAND_W'(signed'({2'b00, s2_r.da})) + CAND_W'(s2_r.cur);
    pf_ok = s2_r.match && !cand[CAND_W-1] &&
            (unsigned'(cand) <= {2'b00, top_address});
  end

  always_comb begin
    s2_v_nxt = s2_v_r;
    if (trn_valid && trn_ready) begin
      s2_v_nxt = 1'b1;
    end else if (s2_adv) begin
      s2_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (s2_adv) begin
      out_v_nxt = 1'b1;
    end else if (res_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (trn_valid && trn_ready) begin
      s2_r <= trn;
    end
    if (s2_adv) begin
      pf_valid_r <= pf_ok;
      pf_addr_r  <= pf_ok ? cand[ADDR_BITS-1:0] : '0;
    end
  end

  assign res_valid          = out_v_r;
  assign res_prefetch_valid = pf_valid_r;
  assign res_prefetch_addr  = pf_addr_r;

`ifndef SYNTHESIS
  a_nopf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !pf_valid_r) |-> (pf_addr_r == '0))
    else $error("address not zero without prefetch");
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !out_adv) |=> (s2_v_r && $stable(s2_r)))
    else $error("stage 2 lost its beat while stalled");
`endif

endmodule

// ===== tb/tb_stride_prefetch_table.sv =====
`timescale 1ns / 1ps

module tb_stride_prefetch_table;
  import spt_pkg::*;

  localparam int STREAMS       = 8;
  localparam int RANDOM_BEATS  = 200;
  localparam int LONG_HOLD     = 120;
  localparam int QUIET_LIMIT   = 1000;
  localparam int PIPE_DRAIN    = 4;
  localparam int TAIL_CYCLES   = 10;
  localparam int IDLE_PCT      = 17;
  localparam int DIRECTED_N    = 24;
  localparam logic [63:0] ADDR_SPAN = 64'h0000_0000_FFFF_FFFF;

  // one prefetch result beat
  typedef struct packed {
    logic  pv;
    addr_t pa;
  } prefetch_t;

  // directed access; typed_exp marks rows whose result is written out here
  typedef struct packed {
    addr_t pc;
    addr_t da;
    logic  typed_exp;
    logic  pv;
    addr_t pa;
  } access_row_t;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  addr_t in_instr_addr;
  addr_t in_data_addr;
  logic  out_valid;
  logic  out_ready;
  logic  out_prefetch_valid;
  addr_t out_prefetch_addr;
  logic  cfg_we;
  addr_t cfg_wdata;

  // predictor state: last data address and stride per slot, plus top address
  addr_t   seen_da     [TABLE_ENTRIES];
  stride_t seen_stride [TABLE_ENTRIES];
  addr_t   top_shadow;

  prefetch_t prefetch_q[$];
  int        mismatches;
  logic      no_gaps;
  logic      hold_request;

  // access streams for the random part
  addr_t stream_pc   [STREAMS];
  addr_t stream_da   [STREAMS];
  int    stream_step [STREAMS];

  access_row_t directed_rows [DIRECTED_N] = '{
    // untrained slot right after reset
    '{32'h0000_0000, 32'h0000_1000, 1'b1, 1'b0, 32'h0},
    // stride differs from zero, gets replaced
    '{32'h0000_0080, 32'h0000_1040, 1'b0, 1'b0, 32'h0},
    // stride repeats, prefetch
    '{32'h0000_0100, 32'h0000_1080, 1'b0, 1'b0, 32'h0},
    // high pc bits ignored, same slot
    '{32'hFFFF_FF80, 32'h0000_10C0, 1'b0, 1'b0, 32'h0},
    // negative candidate, then zero data address untrains the slot
    '{32'h0000_0001, 32'h0000_0100, 1'b1, 1'b0, 32'h0},
    '{32'h0000_0001, 32'h0000_0080, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0001, 32'h0000_0040, 1'b1, 1'b0, 32'h0},
    // candidate above top address
    '{32'h0000_0002, 32'h0FFF_FF00, 1'b1, 1'b0, 32'h0},
    '{32'h0000_0002, 32'h0FFF_FF80, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0002, 32'h1000_0000, 1'b0, 1'b0, 32'h0},
    // candidate exactly at top address
    '{32'h0000_0003, 32'h0FFF_FFFC, 1'b1, 1'b0, 32'h0},
    '{32'h0000_0003, 32'h0FFF_FFFD, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0003, 32'h0FFF_FFFE, 1'b0, 1'b0, 32'h0},
    // all-ones pc and address, widest strides
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
    '{32'h0000_007F, 32'h0000_0001, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    // zero stride matches the reset stride
    '{32'h0000_0004, 32'h0000_0001, 1'b1, 1'b0, 32'h0},
    '{32'h0000_0004, 32'h0000_0001, 1'b0, 1'b0, 32'h0},
    // candidate of exactly zero
    '{32'h0000_0006, 32'h0000_0030, 1'b1, 1'b0, 32'h0},
    '{32'h0000_0006, 32'h0000_0020, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0006, 32'h0000_0010, 1'b0, 1'b0, 32'h0},
    // alternating bit patterns on fresh slots
    '{32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0, 32'h0},
    '{32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b0, 32'h0}
  };

  stride_prefetch_table dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_instr_addr      (in_instr_addr),
    .in_data_addr       (in_data_addr),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_prefetch_valid (out_prefetch_valid),
    .out_prefetch_addr  (out_prefetch_addr),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // train the slot and work out the prefetch candidate for one access
  function automatic prefetch_t predict_prefetch(addr_t pc, addr_t da);
    slot_t     s;
    longint    cur;
    longint    cand;
    prefetch_t r;
    s = pc[SLOT_W-1:0];
    r = '0;
    if (seen_da[s] != '0) begin
      cur = longint'(da) - longint'(seen_da[s]);
      if (cur == longint'(seen_stride[s])) begin
        cand = longint'(da) + cur;
        if (cand >= 0 && cand <= longint'(top_shadow) && cand <= ADDR_SPAN) begin
          r.pv = 1'b1;
          r.pa = addr_t'(cand);
        end
      end else begin
        seen_stride[s] = stride_t'(cur);
      end
    end
    seen_da[s] = da;
    return r;
  endfunction

  function automatic addr_t pick_base();
    addr_t b;
    case ($urandom_range(0, 3))
      0: b = addr_t'($urandom_range(1, 32'h0000_FFFF));
      1: begin
        if (top_shadow > 32'd4096) b = top_shadow - addr_t'($urandom_range(0, 4096));
        else b = addr_t'($urandom_range(0, 4096));
      end
      2: b = 32'hFFFF_FFFF - addr_t'($urandom_range(0, 4096));
      default: b = addr_t'($urandom);
    endcase
    return b;
  endfunction

  function automatic int pick_step();
    int st;
    case ($urandom_range(0, 3))
      0, 1: st = ($urandom_range(0, 64) - 32) * 8;
      2: st = $urandom_range(1, 64);
      default: st = $urandom;
    endcase
    return st;
  endfunction

  // mostly strided streams with random content, some restarts and noise
  function automatic void next_access(output addr_t pc, output addr_t da);
    int k;
    int roll;
    k = $urandom_range(0, STREAMS-1);
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      pc = addr_t'($urandom);
      da = addr_t'($urandom);
    end else begin
      if (roll < 14) begin
        stream_step[k] = pick_step();
        stream_da[k] = stream_da[k] + addr_t'(stream_step[k]);
      end else if (roll < 19) begin
        stream_pc[k] = addr_t'($urandom);
        stream_da[k] = pick_base();
      end else if (roll < 23) begin
        stream_da[k] = '0;
      end else begin
        stream_da[k] = stream_da[k] + addr_t'(stream_step[k]);
      end
      pc = stream_pc[k];
      // vary the bits above the slot index now and then
      if ($urandom_range(0, 3) == 0) pc = pc ^ (addr_t'($urandom) << SLOT_W);
      da = stream_da[k];
    end
  endfunction

  // offer one access beat, wait for it to be taken, queue its result
  task automatic send_access(addr_t pc, addr_t da, logic typed_exp, prefetch_t typed_res);
    prefetch_t want;
    while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_instr_addr <= pc;
    in_data_addr  <= da;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = predict_prefetch(pc, da);
    if (typed_exp) want = typed_res;
    prefetch_q.push_back(want);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (prefetch_q.size() != 0) @(posedge clk);
  endtask

  // register writes only with the pipeline empty
  task automatic write_top_address(addr_t value);
    drain_results();
    repeat (PIPE_DRAIN) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    top_shadow = value;
  endtask

  task automatic run_random(int phase);
    addr_t pc;
    addr_t da;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      // one stretch with no idling on either side
      no_gaps = (phase == 3 && i < 100);
      // long receiver hold-off while accesses keep coming
      if (phase == 1 && i == 50) hold_request = 1'b1;
      // sender waits for every outstanding result
      if (phase == 2 && i == 100) drain_results();
      next_access(pc, da);
      send_access(pc, da, 1'b0, '0);
    end
    no_gaps = 1'b0;
  endtask

  initial begin : stimulus
    addr_t phase_top [4];
    prefetch_t typed_res;
    phase_top[0] = 32'hFFFF_FFFF;
    phase_top[1] = 32'h0000_0000;
    phase_top[2] = addr_t'($urandom);
    phase_top[3] = TOP_ADDR_RESET;
    for (int s = 0; s < TABLE_ENTRIES; s++) begin
      seen_da[s]     = '0;
      seen_stride[s] = '0;
    end
    top_shadow   = TOP_ADDR_RESET;
    mismatches   = 0;
    no_gaps      = 1'b0;
    hold_request = 1'b0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_instr_addr <= '0;
    in_data_addr  <= '0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    for (int k = 0; k < STREAMS; k++) begin
      stream_pc[k]   = addr_t'($urandom);
      stream_da[k]   = pick_base();
      stream_step[k] = pick_step();
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed part under the reset top address
    for (int r = 0; r < DIRECTED_N; r++) begin
      typed_res.pv = directed_rows[r].pv;
      typed_res.pa = directed_rows[r].pa;
      send_access(directed_rows[r].pc, directed_rows[r].da,
                  directed_rows[r].typed_exp, typed_res);
    end
    run_random(0);

    for (int p = 0; p < 4; p++) begin
      write_top_address(phase_top[p]);
      run_random(p + 1);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && prefetch_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // compare each result beat with the oldest queued prediction
  always @(posedge clk) begin : check_results
    prefetch_t want;
    if (rst_n && out_valid && out_ready) begin
      if (prefetch_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, actual valid %0b addr %h",
                 $time, out_prefetch_valid, out_prefetch_addr);
      end else begin
        want = prefetch_q.pop_front();
        if (out_prefetch_valid !== want.pv) begin
          mismatches++;
          $display("%0t: prefetch_valid expected %0b actual %0b",
                   $time, want.pv, out_prefetch_valid);
        end
        if (out_prefetch_addr !== want.pa) begin
          mismatches++;
          $display("%0t: prefetch_addr expected %h actual %h",
                   $time, want.pa, out_prefetch_addr);
        end
      end
    end
  end

  // give up when no beat moves on either side for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/spt_pkg.sv
rtl/spt_ram.sv
rtl/spt_train.sv
rtl/spt_issue.sv
rtl/stride_prefetch_table.sv
tb/tb_stride_prefetch_table.sv
